// ----- hw/rtl/sst_pkg.sv -----
// ----------------------------------------------------------------------------
// Sector slot tracker package
// Shared types, command codes, register indexes and constants.
// ----------------------------------------------------------------------------
package sst_pkg;

	// Fixed field widths and defaults for the top-level parameters.
	localparam int POS_BITS        = 24;
	localparam int MAX_SLOTS_DEF   = 64;
	localparam int JITTER_DEF      = 64;
	localparam int SPACING_BITS    = 16;
	localparam int CFG_ADDR_BITS   = 3;
	localparam int CFG_DATA_BITS   = 16;

	// Tolerance and seeding constants.
	localparam int TOL_LO_MUL      = 97;
	localparam int TOL_HI_MUL      = 103;
	localparam int TOL_DIV         = 100;
	localparam int ADJ_MUL         = 3;
	localparam int ADJ_SHIFT       = 2;

	// Command codes.
	localparam logic [1:0] CMD_HDR     = 2'd0;
	localparam logic [1:0] CMD_DATA    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_BITS-1:0] REG_NOM_SPACING = 3'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_HDR_OFFSET  = 3'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_DATA_OFFSET = 3'd2;
	localparam logic [CFG_ADDR_BITS-1:0] REG_SPT         = 3'd3;
	localparam logic [CFG_ADDR_BITS-1:0] REG_FIRST_SEC   = 3'd4;
	localparam logic [CFG_ADDR_BITS-1:0] REG_HARD_SEC    = 3'd5;
	localparam logic [CFG_ADDR_BITS-1:0] REG_EXP_CYL     = 3'd6;
	localparam logic [CFG_ADDR_BITS-1:0] REG_EXP_SIDE    = 3'd7;

	// Register reset values.
	localparam logic [15:0] NOM_SPACING_RST = 16'd1000;
	localparam logic [15:0] HDR_OFFSET_RST  = 16'd100;
	localparam logic [15:0] DATA_OFFSET_RST = 16'd150;
	localparam logic [6:0]  SPT_RST         = 7'd26;
	localparam logic [7:0]  FIRST_SEC_RST   = 8'd1;

	// Slot flag bit positions.
	localparam int FLAG_HDR  = 0;
	localparam int FLAG_DATA = 1;
	localparam int FLAG_ANY  = 2;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [POS_BITS-1:0] position;
		logic [7:0]          header_sector_id;
		logic [7:0]          header_cylinder;
		logic                header_side;
		logic                data_crc_good;
	} item_t;

	typedef struct packed {
		logic [5:0]              slot_index;
		logic                    slot_ambiguous;
		logic                    slot_saturated;
		logic                    cyl_side_mismatch;
		logic                    id_out_of_range;
		logic                    id_conflict;
		logic                    data_already_good;
		logic [SPACING_BITS-1:0] spacing_now;
		logic [6:0]              good_header_count;
		logic [6:0]              good_data_count;
		logic [6:0]              any_data_count;
	} result_t;

	// Request from the sequencer to the slot store.
	typedef struct packed {
		logic       lookup;
		logic       commit;
		logic       hdr;
		logic       good;
		logic [7:0] sid;
	} store_req_t;

	// Per-event outcome reported by the slot store at commit.
	typedef struct packed {
		logic conflict;
		logic already;
	} store_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_QFLOOR,
		ST_QCEIL,
		ST_QACC,
		ST_QAMBF,
		ST_QAMBC,
		ST_QDELTA,
		ST_QNS,
		ST_SLOT,
		ST_READ,
		ST_COMMIT
	} state_t;

endpackage

// ----- hw/rtl/sector_slot_tracker.sv -----
// ----------------------------------------------------------------------------
// Sector slot tracker
// Assigns sector header and data-field events to sector slots on a track.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration is written through cfg_we / cfg_addr / cfg_data while the
//   block is idle; each write takes effect at the clock edge.
//   An event is transferred when start is high and busy is low. Header and
//   data events each produce one result, shown on result for exactly one
//   cycle with done high. Restart and unused commands finish in the transfer
//   cycle and produce no result.
//   Every quotient comes from one bit-serial divider that yields one bit
//   per cycle, and busy stays high while an event is worked on. An event
//   that continues tracking takes two divisions; an event that seeds
//   tracking takes seven, or five when hard-sectored. An event whose
//   position lies behind its anchor, or whose slot does not move, skips
//   divisions.
//   busy falls in the cycle done is shown, so the next event may be
//   transferred while the result is presented. The receiver cannot stall.
//   Reset clears the configuration to its defaults, the slot flags and the
//   counts, and leaves tracking unseeded. No clearing pass is needed.
// ----------------------------------------------------------------------------
module sector_slot_tracker import sst_pkg::*; #(
	parameter int MAX_SLOTS       = MAX_SLOTS_DEF,
	parameter int POSITION_JITTER = JITTER_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     start,
	input  item_t                    item,
	output logic                     busy,
	output logic                     done,
	output result_t                  result
);

	localparam int PB     = POS_BITS;
	localparam int DW     = PB + 1;
	localparam int ACC_W  = DW + 1;
	localparam int SIDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int SW     = SPACING_BITS;

	// Configuration registers.
	logic [15:0] nom_q, hoff_q, doff_q;
	logic [6:0]  spt_q;
	logic [7:0]  fsn_q, ecyl_q;
	logic        hard_q, eside_q;

	// Tracking state.
	state_t            state_q, state_d;
	logic              valid_q;
	logic [SIDX_W-1:0] last_slot_q;
	logic [PB-1:0]     hanchor_q, danchor_q;
	logic [SW-1:0]     spacing_q, floor_q, ceil_q;
	logic [7:0]        tcyl_q;
	logic              tside_q;

	// Event registers.
	logic              hdr_q, good_q, side_q;
	logic [PB-1:0]     pos_q;
	logic [7:0]        sid_q, cyl_q;
	logic [ACC_W-1:0]  acc_q;
	logic [DW-1:0]     delta_q, qf_q;
	logic [PB-1:0]     p_q;
	logic              amb_q, sat_q, launched_q;
	logic [SIDX_W-1:0] slot_q;
	logic              done_q;
	result_t           result_q;

	// Divider and store connections.
	logic          div_start, div_done;
	logic [DW-1:0] div_a, div_b, div_q;
	store_req_t    sreq;
	store_rsp_t    srsp;
	logic [CNT_W-1:0] hdr_cnt, gd_cnt, any_cnt;

	// Derived values.
	logic             accept;
	logic [SW-1:0]    nom_eff;
	logic [22:0]      prod_lo, prod_hi;
	logic [CNT_W-1:0] spt_eff;
	logic [PB-1:0]    anchor, diff, seed_off, adjust;
	logic             pos_ge_anchor, seed;
	logic [SW-1:0]    ns_clamped;
	logic [7:0]       id_off;
	logic             oor, mism;
	logic [17:0]      adj_prod;

	assign accept  = start && !busy;
	assign nom_eff = (nom_q == '0) ? SW'(1) : nom_q;
	assign prod_lo = 23'(nom_eff) * 23'(TOL_LO_MUL);
	assign prod_hi = 23'(nom_eff) * 23'(TOL_HI_MUL);

	// Slots in use, limited to 1 .. MAX_SLOTS.
	always_comb begin
		if (spt_q == '0) begin
			spt_eff = CNT_W'(1);
		end else if (32'(spt_q) > 32'(MAX_SLOTS)) begin
			spt_eff = CNT_W'(MAX_SLOTS);
		end else begin
			spt_eff = CNT_W'(spt_q);
		end
	end

	// Anchor of the event's own kind and the distance to it.
	assign anchor        = hdr_q ? hanchor_q : danchor_q;
	assign pos_ge_anchor = (pos_q >= anchor);
	assign diff          = pos_q - anchor;
	assign seed          = !valid_q || (pos_q < hanchor_q);

	// Seeding: the other anchor and the ambiguity test position.
	assign seed_off = hdr_q ? (PB'(doff_q) - PB'(hoff_q)) : (PB'(hoff_q) - PB'(doff_q));
	assign adj_prod = 18'(hdr_q ? hoff_q : doff_q) * 18'(ADJ_MUL);
	assign adjust   = PB'(adj_prod >> ADJ_SHIFT);

	// Measured spacing clamped to the tolerance window.
	always_comb begin
		if (div_q > DW'(ceil_q)) begin
			ns_clamped = ceil_q;
		end else if (div_q < DW'(floor_q)) begin
			ns_clamped = floor_q;
		end else begin
			ns_clamped = div_q[SW-1:0];
		end
	end

	// Header checks.
	assign id_off = sid_q - fsn_q;
	assign oor    = (sid_q < fsn_q) || (16'(id_off) >= 16'(spt_eff));
	assign mism   = (cyl_q != tcyl_q) || (side_q != tside_q);

	// Divider operand selection.
	always_comb begin
		div_a = '0;
		div_b = DW'(1);
		case (state_q)
			ST_QFLOOR: begin
				div_a = DW'(prod_lo);
				div_b = DW'(TOL_DIV);
			end
			ST_QCEIL: begin
				div_a = DW'(prod_hi);
				div_b = DW'(TOL_DIV);
			end
			ST_QACC: begin
				div_a = DW'(pos_q);
				div_b = DW'(nom_eff);
			end
			ST_QAMBF: begin
				div_a = DW'(p_q);
				div_b = DW'(floor_q);
			end
			ST_QAMBC: begin
				div_a = DW'(p_q);
				div_b = DW'(ceil_q);
			end
			ST_QDELTA: begin
				div_a = DW'(diff) + DW'(POSITION_JITTER);
				div_b = DW'(spacing_q);
			end
			ST_QNS: begin
				div_a = DW'(diff);
				div_b = delta_q;
			end
			default: begin
				div_a = '0;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (item.cmd == CMD_HDR || item.cmd == CMD_DATA)) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!seed) begin
					state_d = ST_QDELTA;
				end else if (hard_q) begin
					state_d = ST_QACC;
				end else begin
					state_d = ST_QFLOOR;
				end
			end
			ST_QFLOOR: if (div_done) state_d = ST_QCEIL;
			ST_QCEIL:  if (div_done) state_d = ST_QACC;
			ST_QACC:   if (div_done) state_d = ST_QAMBF;
			ST_QAMBF:  if (div_done) state_d = ST_QAMBC;
			ST_QAMBC:  if (div_done) state_d = ST_QDELTA;
			ST_QDELTA: begin
				if (!pos_ge_anchor) begin
					state_d = ST_SLOT;
				end else if (div_done) begin
					state_d = (div_q == '0) ? ST_SLOT : ST_QNS;
				end
			end
			ST_QNS:    if (div_done) state_d = ST_SLOT;
			ST_SLOT:   state_d = ST_READ;
			ST_READ:   state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		busy      = (state_q != ST_IDLE);
		div_start = 1'b0;
		sreq      = '0;
		sreq.hdr  = hdr_q;
		sreq.good = good_q;
		sreq.sid  = sid_q;
		unique case (state_q)
			ST_QFLOOR, ST_QCEIL, ST_QACC, ST_QAMBF, ST_QAMBC, ST_QNS: begin
				div_start = !launched_q;
			end
			ST_QDELTA: begin
				div_start = !launched_q && pos_ge_anchor;
			end
			ST_READ: begin
				sreq.lookup = 1'b1;
			end
			ST_COMMIT: begin
				sreq.commit = 1'b1;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nom_q   <= NOM_SPACING_RST;
			hoff_q  <= HDR_OFFSET_RST;
			doff_q  <= DATA_OFFSET_RST;
			spt_q   <= SPT_RST;
			fsn_q   <= FIRST_SEC_RST;
			hard_q  <= 1'b0;
			ecyl_q  <= '0;
			eside_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_NOM_SPACING: nom_q   <= cfg_data;
				REG_HDR_OFFSET:  hoff_q  <= cfg_data;
				REG_DATA_OFFSET: doff_q  <= cfg_data;
				REG_SPT:         spt_q   <= cfg_data[6:0];
				REG_FIRST_SEC:   fsn_q   <= cfg_data[7:0];
				REG_HARD_SEC:    hard_q  <= cfg_data[0];
				REG_EXP_CYL:     ecyl_q  <= cfg_data[7:0];
				REG_EXP_SIDE:    eside_q <= cfg_data[0];
				default:         nom_q   <= nom_q;
			endcase
		end
	end

	// Tracking datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= 1'b0;
			last_slot_q <= '0;
			hanchor_q   <= '0;
			danchor_q   <= '0;
			spacing_q   <= '0;
			floor_q     <= '0;
			ceil_q      <= '0;
			tcyl_q      <= '0;
			tside_q     <= 1'b0;
			hdr_q       <= 1'b0;
			good_q      <= 1'b0;
			side_q      <= 1'b0;
			pos_q       <= '0;
			sid_q       <= '0;
			cyl_q       <= '0;
			acc_q       <= '0;
			delta_q     <= '0;
			qf_q        <= '0;
			p_q         <= '0;
			amb_q       <= 1'b0;
			sat_q       <= 1'b0;
			launched_q  <= 1'b0;
			slot_q      <= '0;
			done_q      <= 1'b0;
			result_q    <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (div_start) begin
				launched_q <= 1'b1;
			end
			if (div_done) begin
				launched_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hdr_q  <= (item.cmd == CMD_HDR);
						pos_q  <= item.position;
						sid_q  <= item.header_sector_id;
						cyl_q  <= item.header_cylinder;
						side_q <= item.header_side;
						good_q <= item.data_crc_good;
						if (item.cmd == CMD_RESTART) begin
							valid_q <= 1'b0;
							tcyl_q  <= ecyl_q;
							tside_q <= eside_q;
						end
					end
				end
				ST_EVAL: begin
					amb_q <= 1'b0;
					if (seed) begin
						spacing_q <= nom_eff;
						floor_q   <= nom_eff;
						ceil_q    <= nom_eff;
						p_q       <= (pos_q >= adjust) ? (pos_q - adjust) : '0;
						if (hdr_q) begin
							hanchor_q <= pos_q;
							danchor_q <= pos_q + seed_off;
						end else begin
							danchor_q <= pos_q;
							hanchor_q <= pos_q + seed_off;
						end
					end else begin
						acc_q <= ACC_W'(last_slot_q);
					end
				end
				ST_QFLOOR: begin
					if (div_done) begin
						floor_q <= (div_q == '0) ? SW'(1) : div_q[SW-1:0];
					end
				end
				ST_QCEIL: begin
					if (div_done) begin
						ceil_q <= (div_q > DW'({SW{1'b1}})) ? {SW{1'b1}} : div_q[SW-1:0];
					end
				end
				ST_QACC: begin
					if (div_done) begin
						acc_q <= ACC_W'(div_q);
					end
				end
				ST_QAMBF: begin
					if (div_done) begin
						qf_q <= div_q;
					end
				end
				ST_QAMBC: begin
					if (div_done) begin
						amb_q <= (qf_q != div_q);
					end
				end
				ST_QDELTA: begin
					// No slot change: a data event still moves its anchor.
					if (!pos_ge_anchor || (div_done && div_q == '0)) begin
						if (!hdr_q) begin
							danchor_q <= pos_q;
						end
					end else if (div_done) begin
						delta_q <= div_q;
					end
				end
				ST_QNS: begin
					if (div_done) begin
						spacing_q <= ns_clamped;
						acc_q     <= acc_q + ACC_W'(delta_q);
						if (hdr_q) begin
							danchor_q <= danchor_q + pos_q - hanchor_q;
							hanchor_q <= pos_q;
						end else begin
							hanchor_q <= hanchor_q + pos_q - danchor_q;
							danchor_q <= pos_q;
						end
					end
				end
				ST_SLOT: begin
					valid_q <= 1'b1;
					if (acc_q >= ACC_W'(spt_eff)) begin
						slot_q      <= SIDX_W'(spt_eff - 1'b1);
						last_slot_q <= SIDX_W'(spt_eff - 1'b1);
						sat_q       <= 1'b1;
					end else begin
						slot_q      <= acc_q[SIDX_W-1:0];
						last_slot_q <= acc_q[SIDX_W-1:0];
						sat_q       <= 1'b0;
					end
				end
				ST_COMMIT: begin
					if (hdr_q && mism) begin
						tcyl_q  <= cyl_q;
						tside_q <= side_q;
					end
					done_q                     <= 1'b1;
					result_q.slot_index        <= 6'(slot_q);
					result_q.slot_ambiguous    <= amb_q;
					result_q.slot_saturated    <= sat_q;
					result_q.cyl_side_mismatch <= hdr_q && mism;
					result_q.id_out_of_range   <= hdr_q && oor;
					result_q.id_conflict       <= srsp.conflict;
					result_q.data_already_good <= srsp.already;
					result_q.spacing_now       <= spacing_q;
					// Counts as they stand after this event's update.
					result_q.good_header_count <= 7'(hdr_cnt);
					result_q.good_data_count   <= 7'(gd_cnt);
					result_q.any_data_count    <= 7'(any_cnt);
				end
				default: ;
			endcase
		end
	end

	sst_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	sst_store #(
		.MAX_SLOTS (MAX_SLOTS),
		.SIDX_W    (SIDX_W),
		.CNT_W     (CNT_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (sreq),
		.slot    (slot_q),
		.rsp     (srsp),
		.hdr_cnt (hdr_cnt),
		.gd_cnt  (gd_cnt),
		.any_cnt (any_cnt)
	);

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- hw/rtl/sst_div.sv -----
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module sst_div import sst_pkg::*; #(
	parameter int DW = POS_BITS + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   trial;
	logic          fits;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q[DW-1:0], quo_q[DW-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
				quo_q <= {quo_q[DW-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hw/rtl/sst_store.sv -----
// ----------------------------------------------------------------------------
// Slot store
// Per-slot flags, stored sector IDs and the three slot counts.
// ----------------------------------------------------------------------------
module sst_store import sst_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int SIDX_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
	parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  store_req_t        req,
	input  logic [SIDX_W-1:0] slot,
	output store_rsp_t        rsp,
	output logic [CNT_W-1:0]  hdr_cnt,
	output logic [CNT_W-1:0]  gd_cnt,
	output logic [CNT_W-1:0]  any_cnt
);

	logic [2:0]       flags_q [MAX_SLOTS];
	logic [7:0]       id_mem  [MAX_SLOTS];
	logic [2:0]       fl_rd_q;
	logic [7:0]       id_rd_q;
	logic [CNT_W-1:0] hdr_cnt_q;
	logic [CNT_W-1:0] gd_cnt_q;
	logic [CNT_W-1:0] any_cnt_q;
	logic             new_hdr;
	logic             new_data;

	// A header claims the slot only when no good header is there yet.
	assign new_hdr = req.commit && req.hdr && !fl_rd_q[FLAG_HDR];

	// A data field is taken only when the slot has no good data yet.
	assign new_data = req.commit && !req.hdr && !fl_rd_q[FLAG_DATA];

	// Sector ID memory: written once per slot, read into a register.
	always_ff @(posedge clk) begin
		if (new_hdr) begin
			id_mem[slot] <= req.sid;
		end
		if (req.lookup) begin
			id_rd_q <= id_mem[slot];
		end
	end

	// Flags and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				flags_q[i] <= '0;
			end
			fl_rd_q   <= '0;
			hdr_cnt_q <= '0;
			gd_cnt_q  <= '0;
			any_cnt_q <= '0;
		end else begin
			if (req.lookup) begin
				fl_rd_q <= flags_q[slot];
			end
			if (new_hdr) begin
				flags_q[slot][FLAG_HDR] <= 1'b1;
				hdr_cnt_q <= hdr_cnt_q + 1'b1;
			end
			if (new_data) begin
				if (req.good) begin
					flags_q[slot][FLAG_DATA] <= 1'b1;
					gd_cnt_q <= gd_cnt_q + 1'b1;
				end
				if (!fl_rd_q[FLAG_ANY]) begin
					flags_q[slot][FLAG_ANY] <= 1'b1;
					any_cnt_q <= any_cnt_q + 1'b1;
				end
			end
		end
	end

	// Outcome flags; the stored ID is only looked at when the header flag is set.
	always_comb begin
		rsp.conflict = req.hdr && fl_rd_q[FLAG_HDR] && (id_rd_q != req.sid);
		rsp.already  = !req.hdr && fl_rd_q[FLAG_DATA];
	end

	// Counts as they stand once the event being committed is applied.
	assign hdr_cnt = hdr_cnt_q + CNT_W'(new_hdr);
	assign gd_cnt  = gd_cnt_q + CNT_W'(new_data && req.good);
	assign any_cnt = any_cnt_q + CNT_W'(new_data && !fl_rd_q[FLAG_ANY]);

endmodule

// ----- hw/rtl/sst_checker.sv -----
// ----------------------------------------------------------------------------
// Sector slot tracker checker
// Port-level checks of the event and result behavior over time.
// ----------------------------------------------------------------------------
module sst_checker import sst_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input item_t   item,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// A result always closes a busy period and frees the block.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("result shown without a preceding busy period");

	// A header or data transfer always starts work.
	a_event_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.cmd == CMD_HDR || item.cmd == CMD_DATA)) |=> busy)
		else $error("header or data transfer did not start work");

	// A restart transfer finishes at once and produces no result.
	a_restart_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_RESTART) |=> (!busy && !done))
		else $error("restart transfer kept the block busy");

	// Header-only and data-only flags never show together.
	a_flag_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.data_already_good &&
			(result.id_conflict || result.id_out_of_range || result.cyl_side_mismatch)))
		else $error("data and header outcome flags in one result");

endmodule

bind sector_slot_tracker sst_checker u_sst_checker (.*);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Sector slot tracker testbench
// Drives header, data, restart and unused events through the command port,
// rewrites the configuration between phases, and checks every result against
// a cycle-free predictor held in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import sst_pkg::*;

	localparam int SLOTS = 64;
	localparam int JIT = 64;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam longint PMOD = 64'd1 << POS_BITS;
	localparam int WATCHDOG = 20000;

	logic clk, arst_n, cfg_we, start;
	logic [CFG_ADDR_BITS-1:0] cfg_addr;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	item_t item;
	logic busy, done;
	result_t result;

	int n_transfers, n_results, n_idle_cycles;
	bit no_idle;

	sector_slot_tracker DUT (.*);

	// Scoreboard: predicts the tracker and checks each result in order.
	class slot_scoreboard;
		int unsigned nom, hoff, doff, spt_reg, first_sec, hard, exp_cyl, exp_side;
		bit seeded;
		int unsigned last, spacing, sp_floor, sp_ceil, trk_cyl, trk_side;
		longint hanchor, danchor;
		bit [2:0] flags [SLOTS];
		bit [7:0] sid_store [SLOTS];
		int unsigned n_hdr, n_good, n_any;
		result_t pending [$];
		int mismatches;

		function new();
			nom = 1000; hoff = 100; doff = 150; spt_reg = 26; first_sec = 1;
			hard = 0; exp_cyl = 0; exp_side = 0;
			seeded = 0; last = 0; spacing = 0; sp_floor = 0; sp_ceil = 0;
			hanchor = 0; danchor = 0; trk_cyl = 0; trk_side = 0;
			n_hdr = 0; n_good = 0; n_any = 0; mismatches = 0;
			foreach (flags[i]) flags[i] = '0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] v);
			case (idx)
				REG_NOM_SPACING: nom = v;
				REG_HDR_OFFSET:  hoff = v;
				REG_DATA_OFFSET: doff = v;
				REG_SPT:         spt_reg = v[6:0];
				REG_FIRST_SEC:   first_sec = v[7:0];
				REG_HARD_SEC:    hard = v[0];
				REG_EXP_CYL:     exp_cyl = v[7:0];
				default:         exp_side = v[0];
			endcase
		endfunction

		// Notes one transferred event and queues its predicted result.
		function void note_event(item_t it);
			longint pos, acc, anchor, delta, ns, adj, p;
			int unsigned spt, n, slot;
			bit hdr;
			result_t r;
			r = '0;
			pos = it.position;
			hdr = (it.cmd == CMD_HDR);
			spt = (spt_reg == 0) ? 1 : (spt_reg > SLOTS ? SLOTS : spt_reg);
			if (it.cmd == CMD_RESTART) begin
				seeded = 0; trk_cyl = exp_cyl; trk_side = exp_side;
				return;
			end
			if (it.cmd == CMD_UNUSED) return;
			if (!seeded || pos < hanchor) begin
				n = (nom == 0) ? 1 : nom;
				spacing = n;
				if (hard) begin
					sp_floor = n; sp_ceil = n;
				end else begin
					sp_floor = n * 97 / 100;
					sp_ceil = n * 103 / 100;
					if (sp_floor == 0) sp_floor = 1;
					if (sp_ceil > 65535) sp_ceil = 65535;
				end
				acc = pos / spacing;
				if (hdr) begin
					hanchor = pos;
					danchor = (pos + doff + PMOD - hoff) % PMOD;
					adj = longint'(hoff) * 3 / 4;
				end else begin
					danchor = pos;
					hanchor = (pos + hoff + PMOD - doff) % PMOD;
					adj = longint'(doff) * 3 / 4;
				end
				p = (pos >= adj) ? pos - adj : 0;
				r.slot_ambiguous = (p / sp_floor != p / sp_ceil);
			end else begin
				acc = last;
			end
			anchor = hdr ? hanchor : danchor;
			delta = 0;
			if (pos >= anchor) delta = (pos - anchor + JIT) / spacing;
			if (delta == 0) begin
				if (!hdr) danchor = pos;
			end else begin
				ns = (pos - anchor) / delta;
				acc += delta;
				if (ns > sp_ceil) ns = sp_ceil;
				if (ns < sp_floor) ns = sp_floor;
				spacing = 32'(ns);
				if (hdr) begin
					danchor = (danchor + pos + PMOD - hanchor) % PMOD;
					hanchor = pos;
				end else begin
					hanchor = (hanchor + pos + PMOD - danchor) % PMOD;
					danchor = pos;
				end
			end
			if (acc >= spt) begin
				acc = spt - 1;
				r.slot_saturated = 1;
			end
			slot = 32'(acc);
			last = slot;
			seeded = 1;
			if (hdr) begin
				if (it.header_cylinder != trk_cyl || it.header_side != trk_side) begin
					r.cyl_side_mismatch = 1;
					trk_cyl = it.header_cylinder; trk_side = it.header_side;
				end
				r.id_out_of_range = (it.header_sector_id < first_sec) ||
					(it.header_sector_id - first_sec >= spt);
				if (flags[slot][FLAG_HDR]) begin
					r.id_conflict = (sid_store[slot] != it.header_sector_id);
				end else begin
					n_hdr++;
					flags[slot][FLAG_HDR] = 1;
					sid_store[slot] = it.header_sector_id;
				end
			end else begin
				if (flags[slot][FLAG_DATA]) begin
					r.data_already_good = 1;
				end else begin
					if (it.data_crc_good) begin
						flags[slot][FLAG_DATA] = 1;
						n_good++;
					end
					if (!flags[slot][FLAG_ANY]) begin
						flags[slot][FLAG_ANY] = 1;
						n_any++;
					end
				end
			end
			r.slot_index = slot[5:0];
			r.spacing_now = spacing[15:0];
			r.good_header_count = n_hdr[6:0];
			r.good_data_count = n_good[6:0];
			r.any_data_count = n_any[6:0];
			pending.push_back(r);
		endfunction

		// Compares one result with the oldest prediction.
		function void check_result(result_t act);
			result_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("ERROR: unexpected result %h", act);
				return;
			end
			exp_r = pending.pop_front();
			if (act !== exp_r) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result mismatch: expected %p actual %p", exp_r, act);
			end
		endfunction
	endclass

	slot_scoreboard sb;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Results are sampled at the edge that ends their cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(result);
			n_results++;
		end
		if (arst_n && start && !busy) sb.note_event(item);
	end

	// Watchdog on cycles with no transfer, result or configuration write.
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) n_idle_cycles <= 0;
		else n_idle_cycles <= n_idle_cycles + 1;
		if (n_idle_cycles >= WATCHDOG) begin
			$display("watchdog expired");
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_cfg(logic [2:0] idx, logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1; cfg_addr <= idx; cfg_data <= v;
		sb.write_reg(idx, v);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// Presents one event and holds it until the transfer; start stays high
	// afterwards so that events can follow with no gap.
	task automatic send_event(item_t it);
		while (!no_idle && $urandom_range(99) < 13) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1; item <= it;
		do @(posedge clk); while (busy);
		n_transfers++;
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	function automatic item_t make_event(logic [1:0] c, logic [23:0] p, logic [7:0] s);
		item_t it;
		it.cmd = c; it.position = p; it.header_sector_id = s;
		it.header_cylinder = 8'($urandom); it.header_side = 1'($urandom);
		it.data_crc_good = 1'($urandom);
		return it;
	endfunction

	// One pass over the track: header then data per slot, optional noise events, small jitter.
	task automatic track_pass(int nslots, int sp, int ho, int dof, int fs, int chance_noise);
		item_t it;
		int base;
		base = $urandom_range(3);
		for (int s = 0; s < nslots; s++) begin
			if ($urandom_range(99) < chance_noise) begin
				it = make_event(2'($urandom), 24'($urandom), 8'($urandom));
				send_event(it);
			end
			it = make_event(CMD_HDR, 24'(ho + (s + base) * sp + $urandom_range(40) - 20),
				8'(fs + s));
			it.header_cylinder = 8'(sb.exp_cyl); it.header_side = 1'(sb.exp_side);
			if ($urandom_range(9) == 0) it.header_cylinder = 8'($urandom);
			send_event(it);
			it = make_event(CMD_DATA, 24'(dof + (s + base) * sp + $urandom_range(40) - 20),
				8'd0);
			send_event(it);
		end
	endtask

	initial begin
		int sp;
		sb = new();
		arst_n = 0; cfg_we = 0; cfg_addr = '0; cfg_data = '0; start = 0; item = '0;
		n_transfers = 0; n_results = 0; n_idle_cycles = 0; no_idle = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: defaults, extremes of fields, unused command, restart.
		send_event(make_event(CMD_HDR, 24'd0, 8'd0));
		send_event(make_event(CMD_DATA, 24'hFFFFFF, 8'd0));
		send_event(make_event(CMD_UNUSED, 24'h123456, 8'hFF));
		send_event(make_event(CMD_HDR, 24'd100, 8'hFF));
		send_event(make_event(CMD_HDR, 24'd1100, 8'd2));
		send_event(make_event(CMD_HDR, 24'd1100, 8'd9));
		send_event(make_event(CMD_DATA, 24'd1150, 8'd0));
		send_event(make_event(CMD_DATA, 24'd1160, 8'd0));
		send_event(make_event(CMD_RESTART, 24'd0, 8'd0));
		send_event(make_event(CMD_DATA, 24'd50, 8'd0));
		drain();

		// Extreme configuration: zero spacing, large offsets, one slot.
		write_cfg(REG_NOM_SPACING, 16'd0);
		write_cfg(REG_HDR_OFFSET, 16'hFFFF);
		write_cfg(REG_DATA_OFFSET, 16'd0);
		write_cfg(REG_SPT, 16'd0);
		write_cfg(REG_FIRST_SEC, 16'd255);
		write_cfg(REG_HARD_SEC, 16'd1);
		write_cfg(REG_EXP_CYL, 16'd255);
		write_cfg(REG_EXP_SIDE, 16'd1);
		send_event(make_event(CMD_RESTART, 24'd0, 8'd0));
		send_event(make_event(CMD_HDR, 24'd10, 8'd255));
		send_event(make_event(CMD_DATA, 24'd5, 8'd0));
		send_event(make_event(CMD_HDR, 24'd3, 8'd0));
		drain();
		write_cfg(REG_NOM_SPACING, 16'hFFFF);
		write_cfg(REG_SPT, 16'd127);
		write_cfg(REG_HARD_SEC, 16'd0);
		send_event(make_event(CMD_RESTART, 24'd0, 8'd0));
		send_event(make_event(CMD_HDR, 24'hFFFFFF, 8'd0));
		send_event(make_event(CMD_DATA, 24'h7FFFFF, 8'd0));
		drain();

		// Random phases: well-formed passes plus noise, varied settings.
		for (int ph = 0; ph < 12; ph++) begin
			no_idle = (ph == 5);
			sp = (ph % 4 == 0) ? $urandom_range(65535, 30000) : $urandom_range(3000, 200);
			write_cfg(REG_NOM_SPACING, 16'(sp));
			write_cfg(REG_HDR_OFFSET, 16'($urandom_range(200)));
			write_cfg(REG_DATA_OFFSET, 16'($urandom_range(400, 150)));
			write_cfg(REG_SPT, 16'((ph == 3) ? 64 : $urandom_range(30, 1)));
			write_cfg(REG_FIRST_SEC, 16'($urandom_range(3)));
			write_cfg(REG_HARD_SEC, 16'($urandom_range(1)));
			write_cfg(REG_EXP_CYL, 16'($urandom));
			write_cfg(REG_EXP_SIDE, 16'($urandom));
			send_event(make_event(CMD_RESTART, 24'd0, 8'd0));
			while (n_transfers < 40 + (ph + 1) * 45) begin
				track_pass($urandom_range(sb.spt_reg + 2, 1), sp, sb.hoff, sb.doff,
					sb.first_sec, 15);
				if ($urandom_range(3) == 0)
					send_event(make_event(CMD_RESTART, 24'd0, 8'd0));
			end
			drain();
		end

		$display("Covered %0d transfers and %0d checked results over 15 settings.",
			n_transfers, n_results);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d left over", sb.mismatches, sb.pending.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
